// ===== rtl/cfss_pkg.sv =====
package cfss_pkg;

  localparam int NUM_CLASS   = 10;
  localparam int VEC_LEN     = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_H_UP = 8'h48;
  localparam logic [7:0] CH_H_LO = 8'h68;
  localparam logic [7:0] CH_E_UP = 8'h45;
  localparam logic [7:0] CH_E_LO = 8'h65;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_B_LO = 8'h62;

  localparam logic [3:0] IDX_LAST_FRAC = 4'd9;
  localparam logic [3:0] IDX_COS       = 4'd10;
  localparam logic [3:0] IDX_CORR      = 4'd11;
  localparam logic [3:0] IDX_EXP       = 4'd12;
  localparam logic [3:0] IDX_DOT       = 4'd13;

  localparam logic [31:0] ONE_Q28      = 32'h1000_0000;
  localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
  localparam logic [31:0] LN2_Q28      = 32'd186065280;
  localparam logic [4:0]  TAYLOR_TERMS = 5'd16;
  localparam logic [5:0]  EXP_K_MAX    = 6'd40;
  localparam logic [5:0]  FRAC_STEPS   = 6'd29;
  localparam logic [5:0]  WIDE_STEPS   = 6'd32;

  typedef struct packed {
    logic [NUM_CLASS-1:0] hit;
    logic                 last;
  } cfss_item_t;

endpackage

// ===== rtl/cfss_front.sv =====
module cfss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [31:0]         s_tdata_i,
  input  logic                s_tlast_i,
  input  logic                pop_i,
  output logic                valid_o,
  output cfss_pkg::cfss_item_t item_o
);
  import cfss_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0] qs, qb, ms, mb;
  cfss_item_t cls;
  cfss_item_t queue_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;
  logic push, pop;

  assign qs = s_tdata_i[7:0];
  assign qb = s_tdata_i[15:8];
  assign ms = s_tdata_i[23:16];
  assign mb = s_tdata_i[31:24];

  always_comb begin
    cls.hit[0] = (qs == CH_H_UP) || (qs == CH_H_LO);
    cls.hit[1] = (qs == CH_E_UP) || (qs == CH_E_LO);
    cls.hit[2] = (qs == CH_C_UP) || (qs == CH_C_LO);
    cls.hit[3] = (qb == CH_DASH) || (qb == CH_B_LO);
    cls.hit[4] = (qb == CH_E_UP) || (qb == CH_E_LO);
    cls.hit[5] = (ms == CH_H_UP);
    cls.hit[6] = (ms == CH_E_UP);
    cls.hit[7] = (ms == CH_C_UP);
    cls.hit[8] = (mb == CH_DASH) || (mb == CH_B_LO);
    cls.hit[9] = (mb == CH_E_UP) || (mb == CH_E_LO);
    cls.last   = s_tlast_i;
  end

  assign s_tready_o = (cnt_q != CNTW'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign item_o     = queue_q[rd_q];
  assign push       = s_tvalid_i && s_tready_o;
  assign pop        = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_q] <= cls;
    end
  end

endmodule

// ===== rtl/cfss_div.sv =====
module cfss_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rem_i,
  input  logic [31:0] low_i,
  input  logic [63:0] den_i,
  input  logic [5:0]  steps_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic [63:0] rem_q, den_q;
  logic [31:0] low_q, quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] rem2, diff;
  logic        ge;

  assign rem2   = {rem_q, low_q[31]};
  assign ge     = rem2 >= {1'b0, den_q};
  assign diff   = rem2 - {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      low_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= rem_i;
        den_q  <= den_i;
        low_q  <= low_i;
        quo_q  <= '0;
        cnt_q  <= steps_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[63:0] : rem2[63:0];
        low_q <= {low_q[30:0], 1'b0};
        quo_q <= {quo_q[30:0], ge};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule

// ===== rtl/cfss_sqrt.sv =====
module cfss_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q, res_q, bit_q, trial;
  logic        busy_q, done_q;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        v_q    <= val_i;
        res_q  <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("square root restarted while busy");

endmodule

// ===== rtl/cfss_back.sv =====
module cfss_back #(
  parameter int MAX_LEN = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  cfss_pkg::cfss_item_t item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           out_idx_o,
  output logic [31:0]          out_val_o,
  output logic                 out_last_o
);
  import cfss_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int NW = CW + 28;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FRAC, ST_FWAIT, ST_EMIT, ST_MUL, ST_ACC, ST_SQRT, ST_SQWAIT,
    ST_RCHK, ST_RATIO, ST_RWAIT, ST_EXPK, ST_TDIV, ST_TWAIT, ST_EXPFIN
  } state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q [NUM_CLASS];
  logic [CW-1:0] rc_q;
  logic [28:0] fq_q [VEC_LEN];
  logic [28:0] fm_q [VEC_LEN];
  logic [3:0]  idx_q;
  logic [1:0]  ph_q, op_q;
  logic [2:0]  j_q, sel_q;
  logic [63:0] prod_q, dot_q, sq_q, sm_q, dist_q, vq_q, vm_q;
  logic signed [63:0] cnum_q;
  logic [31:0] fsq_q, fsm_q;
  logic [31:0] nq1_q, nm1_q, nq2_q, nm2_q, dd_q;
  logic signed [31:0] res_q;
  logic [31:0] r_q, t_q, r30_q;
  logic [5:0]  k_q;
  logic [4:0]  n_q;
  logic signed [33:0] sum_q;
  logic        out_valid_q, out_last_q;
  logic [3:0]  out_idx_q;
  logic [31:0] out_val_q;

  logic [NW-1:0] frac_num;
  logic [32:0] fa, fb, dfv, dqv, dmv;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic [63:0] cnum_abs, ratio_num;
  logic [29:0] ratio_q;
  logic [32:0] s_pos;
  logic [63:0] exp_rnd;
  logic [6:0]  sh1;
  logic        div_start, div_done, sq_start, sq_done, emit_ok, pop;
  logic [63:0] div_rem, div_den, sq_val;
  logic [31:0] div_low, div_quo, sq_root;
  logic [5:0]  div_steps;
  logic [1:0]  last_op;

  assign frac_num = {cnt_q[idx_q], 28'b0} + NW'(rc_q >> 1);
  assign fa  = {4'b0, fq_q[j_q]};
  assign fb  = {4'b0, fm_q[j_q]};
  assign dfv = (fa > fb) ? (fa - fb) : (fb - fa);
  assign dqv = (fa << 2) + fa - {1'b0, fsq_q};
  assign dmv = (fb << 2) + fb - {1'b0, fsm_q};
  assign mp  = ma * mb;
  assign cnum_abs  = cnum_q[63] ? 64'(-cnum_q) : 64'(cnum_q);
  assign ratio_num = (idx_q == IDX_COS) ? dot_q : cnum_abs;
  assign ratio_q   = (30'(div_quo[28:0]) + 30'd1) >> 1;
  assign s_pos     = sum_q[33] ? 33'd0 : sum_q[32:0];
  assign sh1       = {1'b0, k_q} + 7'd1;
  assign exp_rnd   = ({31'b0, s_pos} + (64'd1 << sh1)) >> (sh1 + 7'd1);
  assign last_op   = (ph_q == 2'd0) ? 2'd3 : 2'd2;
  assign pop       = (state_q == ST_IDLE) && item_valid_i;
  assign emit_ok   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  assign item_pop_o  = pop;
  assign out_valid_o = out_valid_q;
  assign out_idx_o   = out_idx_q;
  assign out_val_o   = out_val_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (ph_q)
      2'd0: begin
        unique case (op_q)
          2'd0: begin ma = fa; mb = fb; end
          2'd1: begin ma = fa; mb = fa; end
          2'd2: begin ma = fb; mb = fb; end
          default: begin ma = dfv; mb = dfv; end
        endcase
      end
      2'd1: begin
        unique case (op_q)
          2'd0: begin ma = dqv; mb = dmv; end
          2'd1: begin ma = dqv; mb = dqv; end
          default: begin ma = dmv; mb = dmv; end
        endcase
      end
      2'd2: begin
        if (idx_q == IDX_COS) begin
          ma = {1'b0, nq1_q};
          mb = {1'b0, nm1_q};
        end else begin
          ma = {1'b0, nq2_q};
          mb = {1'b0, nm2_q};
        end
      end
      default: begin
        ma = {1'b0, t_q};
        mb = {1'b0, r30_q};
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_low   = '0;
    div_den   = prod_q;
    div_steps = FRAC_STEPS;
    priority case (state_q)
      ST_FRAC: begin
        div_start = 1'b1;
        div_rem   = 64'(frac_num >> 29);
        div_low   = {frac_num[28:0], 3'b0};
        div_den   = 64'(rc_q);
      end
      ST_RATIO: begin
        div_start = (ratio_num < prod_q);
        div_rem   = ratio_num;
      end
      ST_TDIV: begin
        div_start = 1'b1;
        div_low   = prod_q[61:30];
        div_den   = 64'(n_q);
        div_steps = WIDE_STEPS;
      end
      default: ;
    endcase
  end

  always_comb begin
    sq_start = (state_q == ST_SQRT);
    unique case (sel_q)
      3'd0: sq_val = sq_q;
      3'd1: sq_val = sm_q;
      3'd2: sq_val = vq_q;
      3'd3: sq_val = vm_q;
      default: sq_val = dist_q;
    endcase
  end

  cfss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .low_i   (div_low),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  cfss_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int c = 0; c < NUM_CLASS; c++) cnt_q[c] <= '0;
      for (int v = 0; v < VEC_LEN; v++) begin
        fq_q[v] <= '0;
        fm_q[v] <= '0;
      end
      rc_q        <= '0;
      idx_q       <= '0;
      ph_q        <= '0;
      op_q        <= '0;
      j_q         <= '0;
      sel_q       <= '0;
      prod_q      <= '0;
      dot_q       <= '0;
      sq_q        <= '0;
      sm_q        <= '0;
      dist_q      <= '0;
      vq_q        <= '0;
      vm_q        <= '0;
      cnum_q      <= '0;
      fsq_q       <= '0;
      fsm_q       <= '0;
      nq1_q       <= '0;
      nm1_q       <= '0;
      nq2_q       <= '0;
      nm2_q       <= '0;
      dd_q        <= '0;
      res_q       <= '0;
      r_q         <= '0;
      t_q         <= '0;
      r30_q       <= '0;
      k_q         <= '0;
      n_q         <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
    end else begin
      if (out_ready_i && !emit_ok) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            for (int c = 0; c < NUM_CLASS; c++) begin
              if (item_i.hit[c] && (cnt_q[c] < CW'(MAX_LEN))) begin
                cnt_q[c] <= cnt_q[c] + CW'(1);
              end
            end
            if (rc_q < CW'(MAX_LEN)) begin
              rc_q <= rc_q + CW'(1);
            end
            if (item_i.last) begin
              idx_q   <= '0;
              dot_q   <= '0;
              sq_q    <= '0;
              sm_q    <= '0;
              dist_q  <= '0;
              vq_q    <= '0;
              vm_q    <= '0;
              cnum_q  <= '0;
              fsq_q   <= '0;
              fsm_q   <= '0;
              state_q <= ST_FRAC;
            end
          end
        end
        ST_FRAC: state_q <= ST_FWAIT;
        ST_FWAIT: begin
          if (div_done) begin
            if (idx_q < 4'(VEC_LEN)) begin
              fq_q[idx_q[2:0]] <= div_quo[28:0];
            end else begin
              fm_q[3'(idx_q - 4'(VEC_LEN))] <= div_quo[28:0];
            end
            res_q   <= $signed({3'b0, div_quo[28:0]});
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= idx_q;
            out_val_q   <= res_q;
            out_last_q  <= (idx_q == IDX_DOT);
            priority if (idx_q < IDX_LAST_FRAC) begin
              idx_q   <= idx_q + 4'd1;
              state_q <= ST_FRAC;
            end else if (idx_q == IDX_LAST_FRAC) begin
              ph_q    <= 2'd0;
              op_q    <= 2'd0;
              j_q     <= '0;
              state_q <= ST_MUL;
            end else if (idx_q == IDX_COS) begin
              idx_q   <= IDX_CORR;
              state_q <= ST_RCHK;
            end else if (idx_q == IDX_CORR) begin
              idx_q   <= IDX_EXP;
              r_q     <= dd_q;
              k_q     <= '0;
              state_q <= ST_EXPK;
            end else if (idx_q == IDX_EXP) begin
              idx_q <= IDX_DOT;
              res_q <= $signed(dot_q[59:28] + 32'(dot_q[27]));
            end else begin
              for (int c = 0; c < NUM_CLASS; c++) cnt_q[c] <= '0;
              rc_q    <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_MUL: begin
          prod_q <= mp[63:0];
          unique case (ph_q)
            2'd0, 2'd1: state_q <= ST_ACC;
            2'd2: state_q <= ST_RATIO;
            default: state_q <= ST_TDIV;
          endcase
        end
        ST_ACC: begin
          if (ph_q == 2'd0) begin
            unique case (op_q)
              2'd0: begin
                dot_q <= dot_q + prod_q;
                fsq_q <= fsq_q + fa[31:0];
                fsm_q <= fsm_q + fb[31:0];
              end
              2'd1: sq_q <= sq_q + prod_q;
              2'd2: sm_q <= sm_q + prod_q;
              default: dist_q <= dist_q + prod_q;
            endcase
          end else begin
            unique case (op_q)
              2'd0: cnum_q <= cnum_q + $signed(prod_q);
              2'd1: vq_q <= vq_q + prod_q;
              default: vm_q <= vm_q + prod_q;
            endcase
          end
          if (op_q == last_op) begin
            op_q <= 2'd0;
            if (j_q == 3'(VEC_LEN - 1)) begin
              j_q <= '0;
              if (ph_q == 2'd0) begin
                ph_q    <= 2'd1;
                state_q <= ST_MUL;
              end else begin
                sel_q   <= '0;
                state_q <= ST_SQRT;
              end
            end else begin
              j_q     <= j_q + 3'd1;
              state_q <= ST_MUL;
            end
          end else begin
            op_q    <= op_q + 2'd1;
            state_q <= ST_MUL;
          end
        end
        ST_SQRT: state_q <= ST_SQWAIT;
        ST_SQWAIT: begin
          if (sq_done) begin
            unique case (sel_q)
              3'd0: nq1_q <= sq_root;
              3'd1: nm1_q <= sq_root;
              3'd2: nq2_q <= sq_root;
              3'd3: nm2_q <= sq_root;
              default: dd_q <= sq_root;
            endcase
            if (sel_q == 3'd4) begin
              idx_q   <= IDX_COS;
              state_q <= ST_RCHK;
            end else begin
              sel_q   <= sel_q + 3'd1;
              state_q <= ST_SQRT;
            end
          end
        end
        ST_RCHK: begin
          if ((idx_q == IDX_COS && (nq1_q == '0 || nm1_q == '0)) ||
              (idx_q == IDX_CORR && (nq2_q == '0 || nm2_q == '0))) begin
            res_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            ph_q    <= 2'd2;
            state_q <= ST_MUL;
          end
        end
        ST_RATIO: begin
          if (ratio_num >= prod_q) begin
            res_q   <= (idx_q == IDX_CORR && cnum_q[63]) ? -$signed(ONE_Q28)
                                                         : $signed(ONE_Q28);
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_RWAIT;
          end
        end
        ST_RWAIT: begin
          if (div_done) begin
            res_q   <= (idx_q == IDX_CORR && cnum_q[63]) ? -$signed({2'b0, ratio_q})
                                                         : $signed({2'b0, ratio_q});
            state_q <= ST_EMIT;
          end
        end
        ST_EXPK: begin
          if (r_q >= LN2_Q28) begin
            r_q <= r_q - LN2_Q28;
            k_q <= k_q + 6'd1;
          end else begin
            r30_q   <= {r_q[29:0], 2'b0};
            t_q     <= ONE_Q30;
            sum_q   <= $signed({2'b0, ONE_Q30});
            n_q     <= 5'd1;
            ph_q    <= 2'd3;
            state_q <= ST_MUL;
          end
        end
        ST_TDIV: state_q <= ST_TWAIT;
        ST_TWAIT: begin
          if (div_done) begin
            t_q <= div_quo;
            if (n_q[0]) begin
              sum_q <= sum_q - $signed({2'b0, div_quo});
            end else begin
              sum_q <= sum_q + $signed({2'b0, div_quo});
            end
            if (n_q == TAYLOR_TERMS) begin
              state_q <= ST_EXPFIN;
            end else begin
              n_q     <= n_q + 5'd1;
              state_q <= ST_MUL;
            end
          end
        end
        ST_EXPFIN: begin
          res_q   <= (k_q > EXP_K_MAX) ? 32'sd0 : $signed(exp_rnd[31:0]);
          state_q <= ST_EMIT;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_clear_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_ok && idx_q == IDX_DOT) |=> (rc_q == '0 && state_q == ST_IDLE))
    else $error("counters not cleared after final score");

  a_last_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_idx_q == IDX_DOT)
    else $error("last flag on wrong score");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FWAIT && div_done) |-> div_quo[31:29] == 3'b0)
    else $error("fraction out of range");

endmodule

// ===== rtl/class_fraction_similarity_scores.sv =====
// Class-fraction similarity scores of a query/model residue stream.
// Input stream: one residue per transaction; tdata holds the query structure,
// query burial, model structure and model burial characters (a byte each),
// tlast marks the final residue of a sequence.
// Output stream: fourteen transactions per sequence, following the final
// residue: the ten class fractions, then cosine, correlation, exp-distance
// and dot product, all signed Q3.28 in tdata; tuser carries the score index
// and tlast flags the dot product.
// Residues enter a four-entry queue and are counted at one per cycle while
// the sequencer is idle. After the final residue the scoring sequencer runs
// on one shared divider, one square-root unit and one multiplier, summing
// 16 Taylor terms for the exponential; the queue keeps taking residues
// of the next sequence until it is full.
// Counters saturate at MAX_LEN and clear after the final score.
// Reset empties the queue and clears all counters; there is no clearing pass.
// When the receiver stalls, the output register holds its transaction and
// the sequencer waits, then the input queue fills and tready drops.
module class_fraction_similarity_scores #(
  parameter int MAX_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] query_structure_char, [15:8] query_burial_char,
  // [23:16] model_structure_char, [31:24] model_burial_char
  input  logic [31:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] score_value
  output logic [31:0] m_axis_tdata_o,
  // [3:0] score_index
  output logic [3:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import cfss_pkg::*;

  cfss_item_t item;
  logic       item_valid, item_pop;

  cfss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .pop_i      (item_pop),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  cfss_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_idx_o    (m_axis_tuser_o),
    .out_val_o    (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule
